// File: hw/rtl/box_filter_bgr_downscaler_macros.svh
// ----------------------------------------------------------------------------
// bfd assertion macros
// shared assertion shorthands for the downscaler checker
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_BGR_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_BGR_DOWNSCALER_MACROS_SVH

// same-cycle implication under async active-low reset
`define BFD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("bfd assertion failed");

// next-cycle implication under async active-low reset
`define BFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("bfd assertion failed");

`endif

// File: hw/rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// constants, register indexes and sequencer states of the bgr downscaler
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int FRAC_BITS   = 16;
	localparam int DIM_W       = 12;
	localparam int COL_W       = 11;
	localparam int EDGE_W      = 28;
	localparam int OVL_W       = 17;
	localparam int WGT_W       = 33;
	localparam int ACC_W       = 40;
	localparam int ADDR_W      = 12;
	localparam int MEM_DEPTH   = 2 * MAX_WIDTH;
	localparam int DIV_STEPS   = EDGE_W;

	localparam logic [7:0] REG_IN_WIDTH   = 8'd0;
	localparam logic [7:0] REG_IN_HEIGHT  = 8'd1;
	localparam logic [7:0] REG_OUT_WIDTH  = 8'd2;
	localparam logic [7:0] REG_OUT_HEIGHT = 8'd3;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_DIVX,
		ST_DIVY,
		ST_IDLE,
		ST_MULW,
		ST_CHK,
		ST_MB,
		ST_MG,
		ST_MR,
		ST_WB,
		ST_ADV
	} bfd_state_t;

endpackage

// File: hw/rtl/box_filter_bgr_downscaler.sv
// ----------------------------------------------------------------------------
// box_filter_bgr_downscaler
// area-averaging downscaler for a raster stream of bgr pixels
// ----------------------------------------------------------------------------
// One input pixel is finished before the next input transaction is taken: an
// accept state, an advance state and, in between, a shared 33x17 multiplier that
// forms the overlap weight and then the three color products for each of up to
// four accumulator updates (states MULW, CHK, MB, MG, MR and WB per touched output
// pixel, MULW and CHK per untouched; the first output pixel is always touched),
// all through one read-modify-write port of the accumulator memory. A finished
// output pixel whose predecessor still waits on m_tready holds the write-back
// until it is taken. After reset and after every register write the block
// clears its 4096-entry accumulator memory and then runs two divisions for the
// edge steps, with s_tready low; configuration writes are taken at any time.
module box_filter_bgr_downscaler import bfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // pix_blue, pix_green, pix_red
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // res_blue, res_green, res_red
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	bfd_state_t state_q, state_d;

	logic [DIM_W-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
	logic [DIM_W-1:0] iw, ih, ow, oh, ow_t, oh_t;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic [EDGE_W-1:0] div_num_q, div_quo_q;
	logic [DIM_W-1:0]  div_rem_q;
	logic [4:0]        div_cnt_q;
	logic [DIM_W-1:0]  div_d;
	logic [DIM_W:0]    div_sh;
	logic [DIM_W:0]    div_rem_n;
	logic              div_bit;
	logic [EDGE_W-1:0] div_quo_n;

	logic [OVL_W-1:0] qsx_q, qsy_q;
	logic [DIM_W-1:0] rsx_q, rsy_q;

	logic [COL_W-1:0]  in_col_q;
	logic [DIM_W-1:0]  in_row_q;
	logic [EDGE_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [DIM_W-1:0]  rx_q, ry_q;
	logic              bank_q;

	logic [7:0] pix_b_q, pix_g_q, pix_r_q;

	logic [COL_W-1:0]  c;
	logic [DIM_W-1:0]  r;
	logic [EDGE_W-1:0] cb, rb;
	logic              col_done, row_done;
	logic [OVL_W-1:0]  wc, sx, wr, sy;

	logic [1:0]        term_q;
	logic [DIM_W-1:0]  term_col;
	logic [ADDR_W-1:0] term_addr;
	logic [OVL_W-1:0]  wa, wb;
	logic              emit_now, skip_term, wb_stall;

	logic [WGT_W-1:0]  mul_a;
	logic [OVL_W-1:0]  mul_b;
	logic [WGT_W+OVL_W-1:0] mul_p;
	logic [WGT_W-1:0]  w_q;

	logic [3*ACC_W-1:0] acc_mem [0:MEM_DEPTH-1];
	logic [3*ACC_W-1:0] rd_data_q;
	logic [ACC_W-1:0]   sum_b_q, sum_g_q, sum_r_q;

	logic              out_valid_q, out_last_q;
	logic [23:0]       out_data_q;

	logic              cfg_hit;
	logic [DIM_W:0]    rx_sum, ry_sum;
	logic [EDGE_W-1:0] x1_step, y1_step;
	logic [DIM_W-1:0]  rx_next, ry_next;
	logic [DIM_W-1:0]  col_inc, row_inc;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_IN_WIDTH || cfg_index == REG_IN_HEIGHT
		|| cfg_index == REG_OUT_WIDTH || cfg_index == REG_OUT_HEIGHT);

	// effective frame sizes
	always_comb begin
		if (in_width_q == '0)
			iw = DIM_W'(1);
		else if (in_width_q > DIM_W'(MAX_WIDTH))
			iw = DIM_W'(MAX_WIDTH);
		else
			iw = in_width_q;
		ih   = (in_height_q == '0) ? DIM_W'(1) : in_height_q;
		ow_t = (out_width_q == '0) ? DIM_W'(1) : out_width_q;
		oh_t = (out_height_q == '0) ? DIM_W'(1) : out_height_q;
		ow   = (ow_t > iw) ? iw : ow_t;
		oh   = (oh_t > ih) ? ih : oh_t;
	end

	// bit-serial restoring divider for the edge steps
	always_comb begin
		div_d     = (state_q == ST_DIVY) ? ih : iw;
		div_sh    = {div_rem_q, div_num_q[EDGE_W-1]};
		div_bit   = div_sh >= {1'b0, div_d};
		div_rem_n = div_bit ? div_sh - {1'b0, div_d} : div_sh;
		div_quo_n = {div_quo_q[EDGE_W-2:0], div_bit};
	end

	// overlaps of the current pixel with its output column and row
	always_comb begin
		c        = x0_q[FRAC_BITS +: COL_W];
		cb       = EDGE_W'({1'b0, c} + 12'd1) << FRAC_BITS;
		col_done = x1_q >= cb;
		wc       = OVL_W'((col_done ? cb : x1_q) - x0_q);
		sx       = col_done ? OVL_W'(x1_q - cb) : '0;
		r        = y0_q[FRAC_BITS +: DIM_W];
		rb       = EDGE_W'({1'b0, r} + 13'd1) << FRAC_BITS;
		row_done = y1_q >= rb;
		wr       = OVL_W'((row_done ? rb : y1_q) - y0_q);
		sy       = row_done ? OVL_W'(y1_q - rb) : '0;
	end

	// term 0: this row and column, 1: next column, 2: next row, 3: both
	always_comb begin
		term_col  = {1'b0, c} + {11'd0, term_q[0]};
		term_addr = {bank_q ^ term_q[1], term_col[COL_W-1:0]};
		wa        = term_q[1] ? sy : wr;
		wb        = term_q[0] ? sx : wc;
		emit_now  = (term_q == 2'd0) && col_done && row_done;
		skip_term = ((w_q == '0) || term_col[COL_W]) && !emit_now;
		wb_stall  = emit_now && out_valid_q && !m_tready;
	end

	// the shared multiplier
	always_comb begin
		case (state_q)
			ST_MB:   begin mul_a = w_q; mul_b = {9'd0, pix_b_q}; end
			ST_MG:   begin mul_a = w_q; mul_b = {9'd0, pix_g_q}; end
			ST_MR:   begin mul_a = w_q; mul_b = {9'd0, pix_r_q}; end
			default: begin mul_a = {16'd0, wa}; mul_b = wb; end
		endcase
		mul_p = mul_a * mul_b;
	end

	// edge advance with a single remainder correction
	always_comb begin
		rx_sum  = {1'b0, rx_q} + {1'b0, rsx_q};
		ry_sum  = {1'b0, ry_q} + {1'b0, rsy_q};
		x1_step = x1_q + EDGE_W'(qsx_q) + EDGE_W'(rx_sum >= {1'b0, iw});
		y1_step = y1_q + EDGE_W'(qsy_q) + EDGE_W'(ry_sum >= {1'b0, ih});
		rx_next = (rx_sum >= {1'b0, iw}) ? DIM_W'(rx_sum - {1'b0, iw}) : DIM_W'(rx_sum);
		ry_next = (ry_sum >= {1'b0, ih}) ? DIM_W'(ry_sum - {1'b0, ih}) : DIM_W'(ry_sum);
		col_inc = {1'b0, in_col_q} + 12'd1;
		row_inc = in_row_q + 12'd1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) state_d = ST_DIVX;
			ST_DIVX: if (div_cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_DIVY;
			ST_DIVY: if (div_cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (s_tvalid) state_d = ST_MULW;
			ST_MULW: state_d = ST_CHK;
			ST_CHK: begin
				if (skip_term)
					state_d = (term_q == 2'd3) ? ST_ADV : ST_MULW;
				else
					state_d = ST_MB;
			end
			ST_MB:   state_d = ST_MG;
			ST_MG:   state_d = ST_MR;
			ST_MR:   state_d = ST_WB;
			ST_WB: begin
				if (!wb_stall)
					state_d = (term_q == 2'd3) ? ST_ADV : ST_MULW;
			end
			ST_ADV:  state_d = ST_IDLE;
			default: state_d = ST_CLR;
		endcase
		if (cfg_hit)
			state_d = ST_CLR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

	// accumulator memory: clearing pass, read-modify-write
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			acc_mem[clr_cnt_q] <= '0;
		else if (state_q == ST_WB && !wb_stall)
			acc_mem[term_addr] <= emit_now ? '0 : {sum_r_q, sum_g_q, sum_b_q};
		rd_data_q <= acc_mem[term_addr];
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_b_q <= s_tdata[7:0];
			pix_g_q <= s_tdata[15:8];
			pix_r_q <= s_tdata[23:16];
		end
		if (state_q == ST_MULW)
			w_q <= mul_p[WGT_W-1:0];
		if (state_q == ST_MB)
			sum_b_q <= rd_data_q[ACC_W-1:0] + mul_p[ACC_W-1:0];
		if (state_q == ST_MG)
			sum_g_q <= rd_data_q[2*ACC_W-1:ACC_W] + mul_p[ACC_W-1:0];
		if (state_q == ST_MR)
			sum_r_q <= rd_data_q[3*ACC_W-1:2*ACC_W] + mul_p[ACC_W-1:0];
		if (state_q == ST_WB && emit_now && !wb_stall) begin
			out_data_q <= {sum_r_q[2*FRAC_BITS +: 8], sum_g_q[2*FRAC_BITS +: 8],
				sum_b_q[2*FRAC_BITS +: 8]};
			out_last_q <= (c == COL_W'(ow - 12'd1)) && (r == (oh - 12'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= 12'd640;
			in_height_q  <= 12'd480;
			out_width_q  <= 12'd320;
			out_height_q <= 12'd240;
			clr_cnt_q    <= '0;
			div_num_q    <= '0;
			div_quo_q    <= '0;
			div_rem_q    <= '0;
			div_cnt_q    <= '0;
			qsx_q        <= '0;
			qsy_q        <= '0;
			rsx_q        <= '0;
			rsy_q        <= '0;
			in_col_q     <= '0;
			in_row_q     <= '0;
			x0_q         <= '0;
			x1_q         <= '0;
			y0_q         <= '0;
			y1_q         <= '0;
			rx_q         <= '0;
			ry_q         <= '0;
			bank_q       <= 1'b0;
			term_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_WB && emit_now && !wb_stall && !cfg_hit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_IN_WIDTH:   in_width_q   <= cfg_data;
					REG_IN_HEIGHT:  in_height_q  <= cfg_data;
					REG_OUT_WIDTH:  out_width_q  <= cfg_data;
					REG_OUT_HEIGHT: out_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_hit) begin
				clr_cnt_q <= '0;
			end else begin
				case (state_q)
					ST_CLR: begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
						div_num_q <= EDGE_W'({ow, 16'd0});
						div_quo_q <= '0;
						div_rem_q <= '0;
						div_cnt_q <= '0;
					end
					ST_DIVX, ST_DIVY: begin
						if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
							div_cnt_q <= '0;
							div_quo_q <= '0;
							div_rem_q <= '0;
							if (state_q == ST_DIVX) begin
								qsx_q     <= div_quo_n[OVL_W-1:0];
								rsx_q     <= div_rem_n[DIM_W-1:0];
								div_num_q <= EDGE_W'({oh, 16'd0});
							end else begin
								// frame restart
								qsy_q    <= div_quo_n[OVL_W-1:0];
								rsy_q    <= div_rem_n[DIM_W-1:0];
								in_col_q <= '0;
								in_row_q <= '0;
								x0_q     <= '0;
								x1_q     <= EDGE_W'(qsx_q);
								rx_q     <= rsx_q;
								y0_q     <= '0;
								y1_q     <= EDGE_W'(div_quo_n[OVL_W-1:0]);
								ry_q     <= div_rem_n[DIM_W-1:0];
								bank_q   <= 1'b0;
							end
						end else begin
							div_num_q <= {div_num_q[EDGE_W-2:0], 1'b0};
							div_quo_q <= div_quo_n;
							div_rem_q <= div_rem_n[DIM_W-1:0];
							div_cnt_q <= div_cnt_q + 1'b1;
						end
					end
					ST_IDLE: term_q <= '0;
					ST_CHK: if (skip_term) term_q <= term_q + 1'b1;
					ST_WB: begin
						if (!wb_stall)
							term_q <= term_q + 1'b1;
					end
					ST_ADV: begin
						if (col_inc >= iw) begin
							in_col_q <= '0;
							x0_q     <= '0;
							x1_q     <= EDGE_W'(qsx_q);
							rx_q     <= rsx_q;
							if (row_done)
								bank_q <= ~bank_q;
							if (row_inc >= ih) begin
								in_row_q <= '0;
								y0_q     <= '0;
								y1_q     <= EDGE_W'(qsy_q);
								ry_q     <= rsy_q;
							end else begin
								in_row_q <= row_inc;
								y0_q     <= y1_q;
								y1_q     <= y1_step;
								ry_q     <= ry_next;
							end
						end else begin
							in_col_q <= col_inc[COL_W-1:0];
							x0_q     <= x1_q;
							x1_q     <= x1_step;
							rx_q     <= rx_next;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hw/rtl/bfd_checker.sv
// ----------------------------------------------------------------------------
// bfd_checker
// port-level checks of the bgr downscaler, bound to the top level
// ----------------------------------------------------------------------------
`include "box_filter_bgr_downscaler_macros.svh"

module bfd_checker import bfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,    // pix_blue, pix_green, pix_red
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,    // res_blue, res_green, res_red
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_index,
	input logic [11:0] cfg_data
);

	logic cfg_known;
	logic s_acc;

	assign cfg_known = cfg_valid && cfg_ready && (cfg_index == REG_IN_WIDTH
		|| cfg_index == REG_IN_HEIGHT || cfg_index == REG_OUT_WIDTH
		|| cfg_index == REG_OUT_HEIGHT);
	assign s_acc = s_tvalid && s_tready && (s_tdata == s_tdata) && (cfg_data == cfg_data);

	// a stalled result transaction holds its payload
	`BFD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// one pixel at a time: no input right after an accepted one
	`BFD_ASSERT_NEXT(a_in_busy, clk, arst_n, s_acc, !s_tready)
	// a register write starts the clearing pass
	`BFD_ASSERT_NEXT(a_cfg_clear, clk, arst_n, cfg_known, !s_tready)

endmodule

bind box_filter_bgr_downscaler bfd_checker u_bfd_checker (.*);
